// ===== rtl/cthp_pkg.sv =====
// Shared types, codes and helpers for the CBOR token header parser.
// No dependencies; used by every module of the block.
package cthp_pkg;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  localparam logic [2:0] KIND_UINT        = 3'd0;
  localparam logic [2:0] KIND_BYTES       = 3'd1;
  localparam logic [2:0] KIND_ARRAY       = 3'd2;
  localparam logic [2:0] KIND_MAP         = 3'd3;
  localparam logic [2:0] KIND_TAG         = 3'd4;
  localparam logic [2:0] KIND_INDEF_ARRAY = 3'd5;
  localparam logic [2:0] KIND_BREAK       = 3'd6;

  localparam logic [7:0] BYTE_INDEF_ARRAY = 8'h9F;
  localparam logic [7:0] BYTE_BREAK       = 8'hFF;

  localparam logic [2:0] MAJOR_UINT  = 3'd0;
  localparam logic [2:0] MAJOR_BYTES = 3'd2;
  localparam logic [2:0] MAJOR_ARRAY = 3'd4;
  localparam logic [2:0] MAJOR_MAP   = 3'd5;
  localparam logic [2:0] MAJOR_TAG   = 3'd6;

  localparam logic [4:0] INFO_W1 = 5'd24;
  localparam logic [4:0] INFO_W2 = 5'd25;
  localparam logic [4:0] INFO_W4 = 5'd26;
  localparam logic [4:0] INFO_W8 = 5'd27;

  typedef enum logic [1:0] {
    OP_RESULT = 2'd0,
    OP_START  = 2'd1,
    OP_VALUE  = 2'd2
  } op_code_t;

  typedef struct packed {
    op_code_t   op;
    status_t    status;
    logic [2:0] kind;
    logic [3:0] width;
    logic [7:0] data;
    logic       final_byte;
    logic       short_end;
  } op_t;

  function automatic logic below_min(input logic [3:0] width, input logic [63:0] v);
    logic res;
    case (width)
      4'd1:    res = (v[63:8] == 56'd0) && (v[7:0] < 8'd24);
      4'd2:    res = (v[63:8] == 56'd0);
      4'd4:    res = (v[63:16] == 48'd0);
      default: res = (v[63:32] == 32'd0);
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/cthp_front.sv =====
// Front end: accepts stream bytes, tracks header/value position, classifies each byte.
// Depends on cthp_pkg.
module cthp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  output logic           byte_stall,
  input  logic [7:0]     data_byte,
  input  logic           end_of_data,
  input  logic           q_full,
  output logic           push,
  output cthp_pkg::op_t  push_op
);
  import cthp_pkg::*;

  logic [3:0] bytes_left;
  logic [3:0] bytes_left_next;
  logic [3:0] left_dec;
  logic [2:0] major;
  logic [4:0] info;
  logic [2:0] kind;
  logic       kind_ok;

  assign byte_stall = q_full;
  assign push       = byte_valid && !q_full;
  assign major      = data_byte[7:5];
  assign info       = data_byte[4:0];
  assign left_dec   = bytes_left - 4'd1;

  always_comb begin
    kind_ok = 1'b1;
    unique case (major)
      MAJOR_UINT:  kind = KIND_UINT;
      MAJOR_BYTES: kind = KIND_BYTES;
      MAJOR_ARRAY: kind = KIND_ARRAY;
      MAJOR_MAP:   kind = KIND_MAP;
      MAJOR_TAG:   kind = KIND_TAG;
      default: begin
        kind    = KIND_UINT;
        kind_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    push_op            = '0;
    push_op.op         = OP_RESULT;
    push_op.status     = ST_OK;
    bytes_left_next    = bytes_left;
    if (bytes_left == 4'd0) begin
      if (data_byte == BYTE_INDEF_ARRAY) begin
        push_op.kind = KIND_INDEF_ARRAY;
      end else if (data_byte == BYTE_BREAK) begin
        push_op.kind = KIND_BREAK;
      end else if (!kind_ok) begin
        push_op.status = ST_BAD;
      end else if (info < INFO_W1) begin
        push_op.kind = kind;
        push_op.data = {3'd0, info};
      end else begin
        unique case (info)
          INFO_W1, INFO_W2, INFO_W4, INFO_W8: begin
            if (end_of_data) begin
              push_op.status = ST_SHORT;
            end else begin
              push_op.op   = OP_START;
              push_op.kind = kind;
              unique case (info)
                INFO_W1: push_op.width = 4'd1;
                INFO_W2: push_op.width = 4'd2;
                INFO_W4: push_op.width = 4'd4;
                default: push_op.width = 4'd8;
              endcase
              bytes_left_next = push_op.width;
            end
          end
          default: push_op.status = ST_BAD;
        endcase
      end
    end else begin
      push_op.op         = OP_VALUE;
      push_op.data       = data_byte;
      push_op.final_byte = (left_dec == 4'd0);
      push_op.short_end  = (left_dec != 4'd0) && end_of_data;
      bytes_left_next    = push_op.short_end ? 4'd0 : left_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 4'd0;
    end else if (push) begin
      bytes_left <= bytes_left_next;
    end
  end

endmodule

// ===== rtl/cthp_queue.sv =====
// Short FIFO of classified operations between front and back end.
// Depends on cthp_pkg.
module cthp_queue #(
  parameter int DEPTH = cthp_pkg::QueueDepth
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cthp_pkg::op_t  push_op,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output cthp_pkg::op_t  q_op
);
  import cthp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  op_t             entries [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == CntW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cthp_back.sv =====
// Back end: gathers value bytes, checks canonical form, holds the result register.
// Depends on cthp_pkg.
module cthp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  cthp_pkg::op_t  q_op,
  output logic           pop,
  output logic           token_valid,
  input  logic           token_stall,
  output logic [1:0]     status,
  output logic [2:0]     token_kind,
  output logic [3:0]     value_width,
  output logic [63:0]    token_value
);
  import cthp_pkg::*;

  logic [2:0]  kind_held;
  logic [3:0]  width_held;
  logic [63:0] value_acc;
  logic [63:0] acc_next;
  logic        advance;
  logic        emit;
  logic [1:0]  res_status;
  logic [2:0]  res_kind;
  logic [3:0]  res_width;
  logic [63:0] res_value;

  assign advance  = !token_valid || !token_stall;
  assign pop      = q_valid && advance;
  assign acc_next = {value_acc[55:0], q_op.data};

  always_comb begin
    emit       = 1'b0;
    res_status = ST_OK;
    res_kind   = KIND_UINT;
    res_width  = 4'd0;
    res_value  = 64'd0;
    unique case (q_op.op)
      OP_RESULT: begin
        emit       = 1'b1;
        res_status = q_op.status;
        res_kind   = q_op.kind;
        res_value  = {56'd0, q_op.data};
      end
      OP_VALUE: begin
        if (q_op.final_byte) begin
          emit = 1'b1;
          if (below_min(width_held, acc_next)) begin
            res_status = ST_BAD;
          end else begin
            res_kind  = kind_held;
            res_width = width_held;
            res_value = acc_next;
          end
        end else if (q_op.short_end) begin
          emit       = 1'b1;
          res_status = ST_SHORT;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (q_op.op)
        OP_START: begin
          kind_held  <= q_op.kind;
          width_held <= q_op.width;
          value_acc  <= 64'd0;
        end
        OP_VALUE: value_acc <= acc_next;
        default: value_acc <= value_acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (advance) begin
      token_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      status      <= res_status;
      token_kind  <= res_kind;
      value_width <= res_width;
      token_value <= res_value;
    end
  end

endmodule

// ===== rtl/cbor_token_header_parser_core.sv =====
// CBOR token header parser: canonical header decode of a byte stream.
// After a token's last byte is transferred, its result passes through the queue and then the result register.
// Throughput: one byte per cycle; the front end stalls only while the queue is full.
// Reset (rst, synchronous): empties the queue, drops any result, expects a header.
// Depends on cthp_pkg, cthp_front, cthp_queue, cthp_back.
module cbor_token_header_parser_core #(
  parameter int QUEUE_DEPTH = cthp_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_data,
  output logic        token_valid,
  input  logic        token_stall,
  output logic [1:0]  status,
  output logic [2:0]  token_kind,
  output logic [3:0]  value_width,
  output logic [63:0] token_value
);
  import cthp_pkg::*;

  logic q_full;
  logic push;
  op_t  push_op;
  logic pop;
  logic q_valid;
  op_t  q_op;

  cthp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .data_byte   (data_byte),
    .end_of_data (end_of_data),
    .q_full      (q_full),
    .push        (push),
    .push_op     (push_op)
  );

  cthp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_op    (q_op)
  );

  cthp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .pop         (pop),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .status      (status),
    .token_kind  (token_kind),
    .value_width (value_width),
    .token_value (token_value)
  );

endmodule
